[design/sirc_pkg.sv]
package sirc_pkg;

  // Built defaults for the top-level parameters
  localparam int MaxSideDefault   = 8;
  localparam int PixelBitsDefault = 8;

  // Fixed field widths
  localparam int SideBits     = 4;
  localparam int PixelOutBits = 8;
  localparam int PixelInBits  = 8;

  // Side length after reset
  localparam logic [SideBits-1:0] SideReset = 4'd8;

  // Address bits for a store of the given depth, never below one
  function automatic int addr_bits(input int depth);
    addr_bits = (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

[design/sirc_ram.sv]
module sirc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = sirc_pkg::addr_bits(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/square_image_rotate_cw_core.sv]
// Square frame rotation, 90 degrees clockwise.
//
// Input channel (in_valid_i / in_ready_o, pixel_in_i) takes one frame of n*n
// pixels in row-major order, one item per cycle while loading. Output channel
// (out_valid_o / out_ready_i, pixel_out_o, frame_last_o) returns the rotated
// frame, also row-major, with frame_last_o high on its final item. The config
// channel (cfg_valid_i / cfg_ready_o, cfg_side_length_i) sets n; 0 acts as 1
// and values above MAX_SIDE act as MAX_SIDE. A write restarts frame loading.
//
// Order: once the last input item is taken, the sequencer enters emission and
// the rotated items pass through the store's registered read and the output
// buffer, then leave one item per cycle while the receiver takes them. The
// frame store has one write and one read port; loading and emitting alternate
// over it, and no input is taken during emission.
// A stalling receiver holds the read sequencer through a two-entry output
// buffer; nothing is dropped.
// Reset clears the counters and state and sets the side to 8. The store
// content is undefined after reset; no clearing pass is made.
module square_image_rotate_cw_core #(
  parameter int MAX_SIDE   = sirc_pkg::MaxSideDefault,
  parameter int PIXEL_BITS = sirc_pkg::PixelBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sirc_pkg::SideBits-1:0]       cfg_side_length_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [sirc_pkg::PixelInBits-1:0]    pixel_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [sirc_pkg::PixelOutBits-1:0]   pixel_out_o,
  output logic                                frame_last_o
);

  localparam int Depth = MAX_SIDE * MAX_SIDE;
  localparam int AddrW = sirc_pkg::addr_bits(Depth);
  localparam int CntW  = sirc_pkg::addr_bits(MAX_SIDE);
  localparam int SideW = sirc_pkg::SideBits;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [SideW-1:0]  side_q, side_d;
  logic [CntW-1:0]   ld_row_q, ld_row_d, ld_col_q, ld_col_d;
  logic [CntW-1:0]   em_row_q, em_row_d, em_col_q, em_col_d;
  logic              rd_valid_q, rd_last_q;

  logic [SideW-1:0]  side_eff;
  logic [CntW-1:0]   nm1;
  logic              in_acc, cfg_acc, ld_end, em_end, issue;
  logic [AddrW-1:0]  waddr, raddr;
  logic [PIXEL_BITS-1:0] rdata;

  logic [sirc_pkg::PixelOutBits-1:0] buf_pix_q [2];
  logic              buf_last_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        occ_q, occ_d;
  logic              pop;
  logic [2:0]        load_lvl;

  // Effective side and last row/column index
  always_comb begin
    side_eff = side_q;
    if (side_q == '0) begin
      side_eff = SideW'(1);
    end else if (side_q > SideW'(MAX_SIDE)) begin
      side_eff = SideW'(MAX_SIDE);
    end
  end
  assign nm1 = CntW'(side_eff - SideW'(1));

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = (state_q == ST_LOAD);
  assign in_acc      = in_valid_i && in_ready_o;
  assign ld_end      = (ld_row_q == nm1) && (ld_col_q == nm1);
  assign em_end      = (em_row_q == nm1) && (em_col_q == nm1);

  // Output buffer fill level after this cycle's pop, counting the read in flight
  assign pop      = out_valid_o && out_ready_i;
  assign load_lvl = {1'b0, occ_q} + {2'b00, rd_valid_q} - {2'b00, pop};
  assign issue    = (state_q == ST_EMIT) && (load_lvl < 3'd2);

  // Store addressing: row stride is MAX_SIDE; rotated read takes (n-1-c, r)
  assign waddr = AddrW'(ld_row_q) * AddrW'(MAX_SIDE) + AddrW'(ld_col_q);
  assign raddr = AddrW'(CntW'(nm1 - em_col_q)) * AddrW'(MAX_SIDE) + AddrW'(em_row_q);

  // Sequencer for load and emit phases
  always_comb begin
    state_d  = state_q;
    side_d   = side_q;
    ld_row_d = ld_row_q;
    ld_col_d = ld_col_q;
    em_row_d = em_row_q;
    em_col_d = em_col_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (ld_end) begin
            ld_row_d = '0;
            ld_col_d = '0;
            state_d  = ST_EMIT;
          end else if (ld_col_q == nm1) begin
            ld_col_d = '0;
            ld_row_d = ld_row_q + CntW'(1);
          end else begin
            ld_col_d = ld_col_q + CntW'(1);
          end
        end
      end
      ST_EMIT: begin
        if (issue) begin
          if (em_end) begin
            em_row_d = '0;
            em_col_d = '0;
            state_d  = ST_LOAD;
          end else if (em_col_q == nm1) begin
            em_col_d = '0;
            em_row_d = em_row_q + CntW'(1);
          end else begin
            em_col_d = em_col_q + CntW'(1);
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
    // A side write abandons a partly loaded frame
    if (cfg_acc) begin
      side_d   = cfg_side_length_i;
      ld_row_d = '0;
      ld_col_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      side_q     <= sirc_pkg::SideReset;
      ld_row_q   <= '0;
      ld_col_q   <= '0;
      em_row_q   <= '0;
      em_col_q   <= '0;
      rd_valid_q <= 1'b0;
      rd_last_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      side_q     <= side_d;
      ld_row_q   <= ld_row_d;
      ld_col_q   <= ld_col_d;
      em_row_q   <= em_row_d;
      em_col_q   <= em_col_d;
      rd_valid_q <= issue;
      rd_last_q  <= issue && em_end;
    end
  end

  // Frame store
  sirc_ram #(
    .WIDTH(PIXEL_BITS),
    .DEPTH(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (in_acc),
    .waddr_i(waddr),
    .wdata_i(PIXEL_BITS'(pixel_in_i)),
    .re_i   (issue),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Two-entry output buffer, filled by returning reads
  always_comb begin
    occ_d = occ_q;
    if (rd_valid_q && !pop) begin
      occ_d = occ_q + 2'd1;
    end else if (!rd_valid_q && pop) begin
      occ_d = occ_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      occ_q    <= '0;
    end else begin
      occ_q <= occ_d;
      if (rd_valid_q) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_valid_q) begin
      buf_pix_q[wr_ptr_q]  <= sirc_pkg::PixelOutBits'(rdata);
      buf_last_q[wr_ptr_q] <= rd_last_q;
    end
  end

  assign out_valid_o  = (occ_q != 2'd0);
  assign pixel_out_o  = buf_pix_q[rd_ptr_q];
  assign frame_last_o = buf_last_q[rd_ptr_q];

  // Checks
  a_buf_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> (occ_q != 2'd2) || pop)
    else $error("read data returned into a full output buffer");

  a_load_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && ld_end && !cfg_acc) |=> (state_q == ST_EMIT) && !in_ready_o)
    else $error("completed frame did not start emission");

  a_emit_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && em_end) |=> (state_q == ST_LOAD) && rd_last_q)
    else $error("final read did not end emission");

  a_emit_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (em_row_q <= nm1) && (em_col_q <= nm1))
    else $error("emit counters beyond frame side");

endmodule
